// ----- src/ebpf_ie_pkg.sv -----
// Shared constants and types for the eBPF instruction execute block.
// Opcode fields, ALU operation codes and the ALU request struct.
// No dependencies.
`default_nettype none

package ebpf_ie_pkg;

    // Instruction classes (opcode bits 2:0)
    localparam logic [2:0] CLS_LDX   = 3'd1;
    localparam logic [2:0] CLS_ST    = 3'd2;
    localparam logic [2:0] CLS_STX   = 3'd3;
    localparam logic [2:0] CLS_ALU   = 3'd4;
    localparam logic [2:0] CLS_JMP   = 3'd5;
    localparam logic [2:0] CLS_ALU64 = 3'd7;

    // ALU operations (opcode bits 7:4)
    localparam logic [3:0] ALU_ADD  = 4'h0;
    localparam logic [3:0] ALU_SUB  = 4'h1;
    localparam logic [3:0] ALU_MUL  = 4'h2;
    localparam logic [3:0] ALU_DIV  = 4'h3;
    localparam logic [3:0] ALU_OR   = 4'h4;
    localparam logic [3:0] ALU_AND  = 4'h5;
    localparam logic [3:0] ALU_LSH  = 4'h6;
    localparam logic [3:0] ALU_RSH  = 4'h7;
    localparam logic [3:0] ALU_MOD  = 4'h9;
    localparam logic [3:0] ALU_XOR  = 4'hA;
    localparam logic [3:0] ALU_MOV  = 4'hB;
    localparam logic [3:0] ALU_ARSH = 4'hC;

    // Conditional jump operations (opcode bits 7:4)
    localparam logic [3:0] JMP_JEQ  = 4'h1;
    localparam logic [3:0] JMP_JGT  = 4'h2;
    localparam logic [3:0] JMP_JGE  = 4'h3;
    localparam logic [3:0] JMP_JSET = 4'h4;
    localparam logic [3:0] JMP_JNE  = 4'h5;
    localparam logic [3:0] JMP_JSGT = 4'h6;
    localparam logic [3:0] JMP_JSGE = 4'h7;

    // Whole opcodes with special meaning
    localparam logic [7:0] OP_LDDW  = 8'h18;
    localparam logic [7:0] OP_JA    = 8'h05;
    localparam logic [7:0] OP_EXIT  = 8'h95;
    localparam logic [7:0] OP_NEG   = 8'h84;
    localparam logic [7:0] OP_NEG64 = 8'h87;
    localparam logic [7:0] OP_TO_LE = 8'hD4;
    localparam logic [7:0] OP_TO_BE = 8'hDC;

    // Memory request codes
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    // Request to the shared ALU
    typedef struct packed {
        logic       start;
        logic [3:0] op;
        logic       wide;
    } alu_req_t;

    // Map opcode size bits to access width code
    function automatic logic [1:0] size_code(input logic [1:0] sz);
        logic [1:0] r;
        case (sz)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd1;
            2'd2:    r = 2'd0;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/ebpf_ie_alu.sv -----
// Shared iterative ALU for the eBPF instruction execute block.
// Simple ops, 32x32 partial-product multiply, 64-step restoring divide.
// Depends on ebpf_ie_pkg.
`default_nettype none

module ebpf_ie_alu
    import ebpf_ie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire alu_req_t    req,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      result
);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_FIN  = 2'd3;

    logic [1:0]  state_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [3:0]  op_reg;
    logic        wide_reg;
    logic [63:0] a_reg, b_reg, acc_reg, prod_reg, rem_reg, quo_reg, result_reg;
    logic [63:0] am, bm, simple;
    logic [5:0]  sh;
    logic [31:0] mul_x, mul_y;
    logic [63:0] acc_sum, fin;
    logic [64:0] trial;
    logic        fit;

    // Mask operands for the 32-bit form
    assign am = req.wide ? a : {32'd0, a[31:0]};
    assign bm = req.wide ? b : {32'd0, b[31:0]};
    assign sh = req.wide ? bm[5:0] : {1'b0, bm[4:0]};

    // Operations that need no iteration
    always_comb
    begin
        case (req.op)
            ALU_ADD:  simple = am + bm;
            ALU_SUB:  simple = am - bm;
            ALU_OR:   simple = am | bm;
            ALU_AND:  simple = am & bm;
            ALU_LSH:  simple = am << sh;
            ALU_RSH:  simple = am >> sh;
            ALU_XOR:  simple = am ^ bm;
            ALU_MOV:  simple = bm;
            ALU_ARSH: simple = 64'($signed(am) >>> sh);
            default:  simple = 64'd0;
        endcase
        if (!req.wide)
            simple = {32'd0, simple[31:0]};
    end

    // Pick the partial product for this multiply step
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin mul_x = a_reg[31:0];  mul_y = b_reg[31:0];  end
            2'd1:    begin mul_x = a_reg[31:0];  mul_y = b_reg[63:32]; end
            default: begin mul_x = a_reg[63:32]; mul_y = b_reg[31:0];  end
        endcase
    end

    assign acc_sum = acc_reg + ((cnt_reg[1:0] == 2'd1) ? prod_reg
                                                       : {prod_reg[31:0], 32'd0});
    assign trial   = {rem_reg, quo_reg[63]};
    assign fit     = trial >= {1'b0, b_reg};

    // Final divide or modulo value, zero divisor handled here
    always_comb
    begin
        if (op_reg == ALU_DIV)
            fin = (b_reg == 64'd0) ? 64'd0 : quo_reg;
        else
            fin = (b_reg == 64'd0) ? a_reg : rem_reg;
        if (!wide_reg)
            fin = {32'd0, fin[31:0]};
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= 6'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        cnt_reg <= 6'd0;
                        if (req.op == ALU_MUL)
                            state_reg <= A_MUL;
                        else if (req.op == ALU_DIV || req.op == ALU_MOD)
                            state_reg <= A_DIV;
                        else
                            done_reg <= 1'b1;
                    end
                end
                A_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                A_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= A_FIN;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                    done_reg  <= 1'b1;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    a_reg      <= am;
                    b_reg      <= bm;
                    op_reg     <= req.op;
                    wide_reg   <= req.wide;
                    acc_reg    <= 64'd0;
                    rem_reg    <= 64'd0;
                    quo_reg    <= am;
                    result_reg <= simple;
                end
            end
            A_MUL:
            begin
                if (cnt_reg[1:0] != 2'd3)
                    prod_reg <= 64'(mul_x * mul_y);
                if (cnt_reg[1:0] != 2'd0)
                    acc_reg <= acc_sum;
                if (cnt_reg[1:0] == 2'd3)
                    result_reg <= wide_reg ? acc_sum : {32'd0, acc_sum[31:0]};
            end
            A_DIV:
            begin
                rem_reg <= fit ? 64'(trial - {1'b0, b_reg}) : trial[63:0];
                quo_reg <= {quo_reg[62:0], fit};
            end
            default:
            begin
                result_reg <= fin;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- src/ebpf_instruction_execute_top.sv -----
// Top level of the eBPF instruction execute block: stream ports, register
// file, decode, sequencer and output register. Depends on ebpf_ie_pkg and
// ebpf_ie_alu.
//
// Each request is one eBPF instruction or one load return, and gives exactly
// one result. A request passes through accept, register read, execute and
// write back; an ALU operation also waits on the shared ALU, whose divide or
// modulo runs a one-bit-per-cycle divider loop. The block takes no new
// request until the current one has reached the output register; a finished
// result may wait there while the next request enters.
// Registers at or above NUM_REGS read as zero and ignore writes.
`default_nettype none

module ebpf_instruction_execute_top
    import ebpf_ie_pkg::*;
#(
    parameter int NUM_REGS = 10
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode, dst_index, src_index, offset, immediate, immediate_upper, load_data
    input  wire logic [159:0] s_tdata,
    // kind
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // branch_taken, branch_offset, program_exit, mem_op, mem_address, mem_size,
    // store_value, dst_value, unknown_opcode, one pad bit
    output logic [215:0]      m_tdata
);

    localparam int         IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [4:0] NREG_W = 5'(NUM_REGS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]  state_reg;

    // Latched request fields
    logic        kind_reg;
    logic [7:0]  op_reg;
    logic [3:0]  dst_reg, src_reg;
    logic [15:0] off_reg;
    logic [31:0] imm_reg, up_reg;
    logic [63:0] ld_reg;

    // Register file
    logic [63:0]         regs_mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [63:0]         dv_reg, sv_reg;
    logic [3:0]          rd_a;
    logic                load_pending_reg;
    logic [3:0]          load_target_reg;

    // Execute results
    logic        wb_en_reg, use_alu_reg, set_pend_reg, clr_pend_reg;
    logic [3:0]  wb_idx_reg;
    logic [63:0] wb_data_reg;
    logic        taken_reg, exit_reg, unk_reg;
    logic [15:0] boff_reg;
    logic [1:0]  mop_reg, msz_reg;
    logic [63:0] addr_reg, sval_reg;

    // Output register
    logic        out_valid_reg;
    logic        o_taken_reg, o_exit_reg, o_unk_reg;
    logic [15:0] o_boff_reg;
    logic [1:0]  o_mop_reg, o_msz_reg;
    logic [63:0] o_addr_reg, o_sval_reg, o_dval_reg;

    // Decode wires
    logic        wb_en, use_alu, set_pend, clr_pend, taken, ex, unk, wide;
    logic [3:0]  wb_idx;
    logic [63:0] wb_data, addr, sval, offx, immx, kx, neg;
    logic [1:0]  mop, msz;
    logic [2:0]  cls;
    logic [3:0]  opr;

    logic        accept, commit, wr_ok;
    alu_req_t    alu_req;
    logic        alu_done;
    logic [63:0] alu_result;

    function automatic logic in_range(input logic [3:0] idx);
        return {1'b0, idx} < NREG_W;
    endfunction

    assign accept = s_tvalid && s_tready;
    assign commit = (state_reg == S_WB) && (!out_valid_reg || m_tready);
    assign wr_ok  = wb_en_reg && in_range(wb_idx_reg);
    assign rd_a   = kind_reg ? load_target_reg : dst_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:  if (accept) state_reg <= S_READ;
                S_READ:  state_reg <= S_EXEC;
                S_EXEC:  state_reg <= use_alu ? S_ALU : S_WB;
                S_ALU:   if (alu_done) state_reg <= S_WB;
                S_WB:    if (commit) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser[0];
            op_reg   <= s_tdata[7:0];
            dst_reg  <= s_tdata[11:8];
            src_reg  <= s_tdata[15:12];
            off_reg  <= s_tdata[31:16];
            imm_reg  <= s_tdata[63:32];
            up_reg   <= s_tdata[95:64];
            ld_reg   <= s_tdata[159:96];
        end
    end

    // Register file read and write
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            dv_reg <= (in_range(rd_a) && valid_reg[rd_a[IDX_W-1:0]])
                      ? regs_mem[rd_a[IDX_W-1:0]] : 64'd0;
            sv_reg <= (in_range(src_reg) && valid_reg[src_reg[IDX_W-1:0]])
                      ? regs_mem[src_reg[IDX_W-1:0]] : 64'd0;
        end
        if (commit && wr_ok)
            regs_mem[wb_idx_reg[IDX_W-1:0]] <= wb_data_reg;
    end

    // Valid bits and load tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            load_pending_reg <= 1'b0;
            load_target_reg  <= 4'd0;
        end
        else if (commit)
        begin
            if (wr_ok)
                valid_reg[wb_idx_reg[IDX_W-1:0]] <= 1'b1;
            if (clr_pend_reg)
                load_pending_reg <= 1'b0;
            if (set_pend_reg)
            begin
                load_pending_reg <= 1'b1;
                load_target_reg  <= dst_reg;
            end
        end
    end

    // Decode and execute everything but ALU operations
    assign cls  = op_reg[2:0];
    assign opr  = op_reg[7:4];
    assign wide = (cls == CLS_ALU64);
    assign offx = {{48{off_reg[15]}}, off_reg};
    assign immx = {{32{imm_reg[31]}}, imm_reg};
    assign kx   = op_reg[3] ? sv_reg : immx;
    assign neg  = 64'd0 - dv_reg;

    always_comb
    begin
        wb_en    = 1'b0;
        wb_idx   = dst_reg;
        wb_data  = 64'd0;
        use_alu  = 1'b0;
        set_pend = 1'b0;
        clr_pend = 1'b0;
        taken    = 1'b0;
        ex       = 1'b0;
        unk      = 1'b0;
        mop      = MEM_NONE;
        msz      = 2'd0;
        addr     = 64'd0;
        sval     = 64'd0;
        if (kind_reg)
        begin
            wb_en    = load_pending_reg;
            wb_idx   = load_target_reg;
            wb_data  = ld_reg;
            clr_pend = 1'b1;
        end
        else if (op_reg == OP_LDDW)
        begin
            wb_en   = 1'b1;
            wb_data = {up_reg, imm_reg};
        end
        else if ((cls == CLS_LDX || cls == CLS_ST || cls == CLS_STX)
                 && op_reg[7:5] == 3'b011)
        begin
            msz = size_code(op_reg[4:3]);
            if (cls == CLS_LDX)
            begin
                mop      = MEM_LOAD;
                addr     = sv_reg + offx;
                set_pend = 1'b1;
            end
            else
            begin
                mop  = MEM_STORE;
                addr = dv_reg + offx;
                sval = (cls == CLS_STX) ? sv_reg : immx;
            end
        end
        else if (cls == CLS_JMP)
        begin
            if (op_reg == OP_JA)
                taken = 1'b1;
            else if (op_reg == OP_EXIT)
                ex = 1'b1;
            else
            begin
                case (opr)
                    JMP_JEQ:  taken = dv_reg == kx;
                    JMP_JGT:  taken = dv_reg > kx;
                    JMP_JGE:  taken = dv_reg >= kx;
                    JMP_JSET: taken = (dv_reg & kx) != 64'd0;
                    JMP_JNE:  taken = dv_reg != kx;
                    JMP_JSGT: taken = $signed(dv_reg) > $signed(kx);
                    JMP_JSGE: taken = $signed(dv_reg) >= $signed(kx);
                    default:  unk = 1'b1;
                endcase
            end
        end
        else if (cls == CLS_ALU || cls == CLS_ALU64)
        begin
            if (opr inside {[ALU_ADD:ALU_RSH], ALU_MOD, ALU_XOR, ALU_MOV}
                || (opr == ALU_ARSH && wide))
                use_alu = 1'b1;
            else if (op_reg == OP_NEG || op_reg == OP_NEG64)
            begin
                wb_en   = 1'b1;
                wb_data = wide ? neg : {32'd0, neg[31:0]};
            end
            else if (op_reg == OP_TO_LE || op_reg == OP_TO_BE)
            begin
                // Unsupported widths leave dst alone
                if (imm_reg == 32'd16)
                begin
                    wb_en   = 1'b1;
                    wb_data = (op_reg == OP_TO_BE)
                              ? {48'd0, dv_reg[7:0], dv_reg[15:8]}
                              : {48'd0, dv_reg[15:0]};
                end
                else if (imm_reg == 32'd32)
                begin
                    wb_en   = 1'b1;
                    wb_data = (op_reg == OP_TO_BE)
                              ? {32'd0, dv_reg[7:0], dv_reg[15:8],
                                 dv_reg[23:16], dv_reg[31:24]}
                              : {32'd0, dv_reg[31:0]};
                end
                else if (imm_reg == 32'd64)
                begin
                    wb_en   = 1'b1;
                    wb_data = (op_reg == OP_TO_BE)
                              ? {dv_reg[7:0], dv_reg[15:8], dv_reg[23:16],
                                 dv_reg[31:24], dv_reg[39:32], dv_reg[47:40],
                                 dv_reg[55:48], dv_reg[63:56]}
                              : dv_reg;
                end
            end
            else
                unk = 1'b1;
        end
        else
            unk = 1'b1;
    end

    // Shared ALU
    assign alu_req.start = (state_reg == S_EXEC) && use_alu;
    assign alu_req.op    = opr;
    assign alu_req.wide  = wide;

    ebpf_ie_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (dv_reg),
        .b      (kx),
        .done   (alu_done),
        .result (alu_result)
    );

    // Hold execute results until write back
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            wb_en_reg    <= wb_en || use_alu;
            wb_idx_reg   <= wb_idx;
            wb_data_reg  <= wb_data;
            use_alu_reg  <= use_alu;
            set_pend_reg <= set_pend;
            clr_pend_reg <= clr_pend;
            taken_reg    <= taken;
            boff_reg     <= taken ? off_reg : 16'd0;
            exit_reg     <= ex;
            unk_reg      <= unk;
            mop_reg      <= mop;
            msz_reg      <= msz;
            addr_reg     <= addr;
            sval_reg     <= sval;
        end
        else if (state_reg == S_ALU && alu_done)
            wb_data_reg <= alu_result;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            o_taken_reg <= taken_reg;
            o_boff_reg  <= boff_reg;
            o_exit_reg  <= exit_reg;
            o_mop_reg   <= mop_reg;
            o_addr_reg  <= addr_reg;
            o_msz_reg   <= msz_reg;
            o_sval_reg  <= sval_reg;
            o_dval_reg  <= wr_ok ? wb_data_reg : dv_reg;
            o_unk_reg   <= unk_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, o_unk_reg, o_dval_reg, o_sval_reg, o_msz_reg,
                       o_addr_reg, o_mop_reg, o_exit_reg, o_boff_reg, o_taken_reg};

    // An unknown opcode reports no branch, exit or memory request
    a_unk_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && o_unk_reg) |-> (!o_taken_reg && !o_exit_reg
                                     && o_mop_reg == MEM_NONE))
        else $error("unknown opcode result carries side effects");

    // No memory request means zero address and store value
    a_mem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && o_mop_reg == MEM_NONE) |-> (o_addr_reg == 64'd0
                                                 && o_sval_reg == 64'd0))
        else $error("address or store value without a memory request");

    // A load becomes pending only on a write back
    a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(load_pending_reg) |-> $past(state_reg == S_WB))
        else $error("load pending set outside write back");

    // ALU completes only while the sequencer waits for it
    a_alu_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_ALU && use_alu_reg))
        else $error("ALU done while not awaited");

endmodule

`default_nettype wire

// ----- tb/tb_ebpf_instruction_execute_top.sv -----
// Testbench for ebpf_instruction_execute_top: a directed table, then random
// instruction streams, each result checked against a built-in predictor.
// Depends on ebpf_ie_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_ebpf_instruction_execute_top;
    import ebpf_ie_pkg::*;

    localparam int NREGS = 10;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic        kind;
        logic [7:0]  opcode;
        logic [3:0]  dst;
        logic [3:0]  src;
        logic [15:0] offset;
        logic [31:0] imm;
        logic [31:0] imm_hi;
        logic [63:0] ldata;
    } req_t;

    // Packed from the highest bit down, so branch_taken lands in bit 0
    typedef struct packed {
        logic        unk;
        logic [63:0] dval;
        logic [63:0] sval;
        logic [1:0]  msz;
        logic [63:0] addr;
        logic [1:0]  mop;
        logic        ex;
        logic [15:0] boff;
        logic        taken;
    } res_t;

    // Directed row: request plus optional typed-in expected result
    typedef struct {
        req_t req;
        bit   has_exp;
        res_t exp;
    } row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [159:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [215:0] m_tdata;

    ebpf_instruction_execute_top #(.NUM_REGS(NREGS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state
    logic [63:0] regs [NREGS];
    logic        ld_pending;
    logic [3:0]  ld_target;

    res_t expected_results [$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   recv_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAIL ebpf_instruction_execute_top");
        $finish;
    end

    function automatic logic [63:0] rd(input logic [3:0] i);
        return (i < NREGS) ? regs[i] : 64'd0;
    endfunction

    function automatic logic [63:0] bswap(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < n; k++)
            r[8*(n-1-k) +: 8] = v[8*k +: 8];
        return r;
    endfunction

    function automatic logic [63:0] alu_result(input logic [3:0] op, input logic [63:0] a_in,
                                               input logic [63:0] b_in, input bit wide);
        logic [63:0] a, b, r;
        a = wide ? a_in : {32'd0, a_in[31:0]};
        b = wide ? b_in : {32'd0, b_in[31:0]};
        case (op)
            ALU_ADD: r = a + b;
            ALU_SUB: r = a - b;
            ALU_MUL: r = a * b;
            ALU_DIV: r = (b != 0) ? a / b : 64'd0;
            ALU_OR:  r = a | b;
            ALU_AND: r = a & b;
            ALU_LSH: r = a << (wide ? b[5:0] : {1'b0, b[4:0]});
            ALU_RSH: r = a >> (wide ? b[5:0] : {1'b0, b[4:0]});
            ALU_MOD: r = (b != 0) ? a % b : a;
            ALU_XOR: r = a ^ b;
            ALU_MOV: r = b;
            default: r = $signed(a) >>> b[5:0];
        endcase
        return wide ? r : {32'd0, r[31:0]};
    endfunction

    // Execute one request on the predictor and return its result
    function automatic res_t execute_request(input req_t q);
        res_t o;
        logic [63:0] dv, sv, kx, offx, immx;
        logic [2:0] cls;
        logic [3:0] opr;
        bit wide;
        o = '0;
        dv = rd(q.dst);
        sv = rd(q.src);
        offx = {{48{q.offset[15]}}, q.offset};
        immx = {{32{q.imm[31]}}, q.imm};
        kx = q.opcode[3] ? sv : immx;
        cls = q.opcode[2:0];
        opr = q.opcode[7:4];
        if (q.kind)
        begin
            if (ld_pending)
            begin
                if (ld_target < NREGS) regs[ld_target] = q.ldata;
                ld_pending = 1'b0;
            end
            o.dval = rd(ld_target);
            return o;
        end
        if (q.opcode == OP_LDDW)
        begin
            if (q.dst < NREGS) regs[q.dst] = {q.imm_hi, q.imm};
        end
        else if (cls >= CLS_LDX && cls <= CLS_STX && q.opcode[7:5] == 3'b011)
        begin
            o.msz = size_code(q.opcode[4:3]);
            if (cls == CLS_LDX)
            begin
                o.mop = MEM_LOAD;
                o.addr = sv + offx;
                ld_pending = 1'b1;
                ld_target = q.dst;
            end
            else
            begin
                o.mop = MEM_STORE;
                o.addr = dv + offx;
                o.sval = (cls == CLS_STX) ? sv : immx;
            end
        end
        else if (cls == CLS_JMP)
        begin
            if (q.opcode == OP_JA) o.taken = 1'b1;
            else if (q.opcode == OP_EXIT) o.ex = 1'b1;
            else if (opr >= JMP_JEQ && opr <= JMP_JSGE)
            begin
                case (opr)
                    JMP_JEQ:  o.taken = dv == kx;
                    JMP_JGT:  o.taken = dv > kx;
                    JMP_JGE:  o.taken = dv >= kx;
                    JMP_JSET: o.taken = (dv & kx) != 0;
                    JMP_JNE:  o.taken = dv != kx;
                    JMP_JSGT: o.taken = $signed(dv) > $signed(kx);
                    default:  o.taken = $signed(dv) >= $signed(kx);
                endcase
            end
            else o.unk = 1'b1;
            if (o.taken) o.boff = q.offset;
        end
        else if (cls == CLS_ALU || cls == CLS_ALU64)
        begin
            wide = (cls == CLS_ALU64);
            if (opr <= ALU_RSH || opr == ALU_MOD || opr == ALU_XOR || opr == ALU_MOV
                || (opr == ALU_ARSH && wide))
            begin
                if (q.dst < NREGS) regs[q.dst] = alu_result(opr, dv, kx, wide);
            end
            else if (q.opcode == OP_NEG || q.opcode == OP_NEG64)
            begin
                if (q.dst < NREGS) regs[q.dst] = wide ? -dv : {32'd0, -dv[31:0]};
            end
            else if (q.opcode == OP_TO_LE || q.opcode == OP_TO_BE)
            begin
                if (q.dst < NREGS)
                begin
                    if (q.imm == 32'd16)
                        regs[q.dst] = (q.opcode == OP_TO_BE) ? bswap(dv, 2) : {48'd0, dv[15:0]};
                    else if (q.imm == 32'd32)
                        regs[q.dst] = (q.opcode == OP_TO_BE) ? bswap(dv, 4) : {32'd0, dv[31:0]};
                    else if (q.imm == 32'd64)
                        regs[q.dst] = (q.opcode == OP_TO_BE) ? bswap(dv, 8) : dv;
                end
            end
            else o.unk = 1'b1;
        end
        else o.unk = 1'b1;
        o.dval = rd(q.dst);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Check every result taken at the output
    always @(posedge clk)
    begin
        res_t g, e;
        if (rst_n && m_tvalid && m_tready)
        begin
            g = m_tdata[214:0];
            if (expected_results.size() == 0)
                report_mismatch("result without request", g.dval, 64'd0);
            else
            begin
                e = expected_results.pop_front();
                if (g.taken !== e.taken)
                    report_mismatch("branch_taken", 64'(g.taken), 64'(e.taken));
                if (g.boff !== e.boff)
                    report_mismatch("branch_offset", 64'(g.boff), 64'(e.boff));
                if (g.ex !== e.ex)
                    report_mismatch("program_exit", 64'(g.ex), 64'(e.ex));
                if (g.mop !== e.mop)
                    report_mismatch("mem_op", 64'(g.mop), 64'(e.mop));
                if (g.addr !== e.addr) report_mismatch("mem_address", g.addr, e.addr);
                if (g.msz !== e.msz)
                    report_mismatch("mem_size", 64'(g.msz), 64'(e.msz));
                if (g.sval !== e.sval) report_mismatch("store_value", g.sval, e.sval);
                if (g.dval !== e.dval) report_mismatch("dst_value", g.dval, e.dval);
                if (g.unk !== e.unk)
                    report_mismatch("unknown_opcode", 64'(g.unk), 64'(e.unk));
            end
        end
    end

    // Receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one request; valid stays high after acceptance until the next call
    task automatic send_request(input req_t q, input bit has_exp, input res_t want);
        res_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.kind;
        s_tdata <= {q.ldata, q.imm_hi, q.imm, q.offset, q.src, q.dst, q.opcode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        p = execute_request(q);
        if (has_exp && p !== want) report_mismatch("directed row", p.dval, want.dval);
        expected_results.push_back(p);
    endtask

    function automatic req_t instr(input logic [7:0] op, input logic [3:0] d,
                                   input logic [3:0] s, input logic [15:0] off,
                                   input logic [31:0] imm, input logic [31:0] hi);
        req_t q;
        q = '0;
        q.opcode = op; q.dst = d; q.src = s; q.offset = off; q.imm = imm; q.imm_hi = hi;
        return q;
    endfunction

    function automatic res_t dval_only(input logic [63:0] v, input bit unk);
        res_t o;
        o = '0;
        o.dval = v;
        o.unk = unk;
        return o;
    endfunction

    // Random request, mostly well-formed instructions on small register range
    function automatic req_t random_request();
        req_t q;
        logic [3:0] opr;
        int pick;
        q = '0;
        q.dst = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NREGS-1));
        q.src = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NREGS-1));
        q.offset = 16'($urandom);
        q.imm = ($urandom_range(3) == 0) ? 32'($urandom_range(70)) : $urandom;
        q.imm_hi = $urandom;
        q.ldata = {$urandom, $urandom};
        pick = $urandom_range(99);
        opr = 4'($urandom_range(15));
        if (pick < 8)
        begin
            q.kind = 1'b1;
        end
        else if (pick < 14)
        begin
            q.opcode = OP_LDDW;
        end
        else if (pick < 55)
        begin
            // ALU, avoiding long divides most of the time
            if ((opr == ALU_DIV || opr == ALU_MOD) && $urandom_range(3) != 0) opr = ALU_XOR;
            q.opcode = {opr, 1'($urandom), ($urandom_range(1) ? CLS_ALU64 : CLS_ALU)};
            if (q.opcode[7:4] == 4'hD) q.imm = 32'(16 << $urandom_range(2));
        end
        else if (pick < 75)
        begin
            q.opcode = {opr, 1'($urandom), CLS_JMP};
        end
        else if (pick < 92)
        begin
            q.opcode = {3'b011, 2'($urandom), 3'($urandom_range(1, 3))};
        end
        else
        begin
            q.opcode = 8'($urandom);
        end
        return q;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        row_t rows [$];
        row_t r;
        errors = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        recv_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NREGS; i++) regs[i] = '0;
        ld_pending = 1'b0;
        ld_target = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        r.req = '0; r.req.kind = 1'b1; r.req.ldata = '1;
        r.has_exp = 1; r.exp = dval_only(64'd0, 0); rows.push_back(r);
        r.req = instr(OP_LDDW, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        r.exp = dval_only('1, 0); rows.push_back(r);
        r.req = instr(OP_LDDW, 2, 0, 0, 32'h0102_0304, 32'h0506_0708);
        r.exp = dval_only(64'h0506_0708_0102_0304, 0); rows.push_back(r);
        r.req = instr({ALU_DIV, 1'b0, CLS_ALU64}, 3, 0, 0, 0, 0);
        r.exp = dval_only(0, 0); rows.push_back(r);
        r.req = instr({ALU_MOD, 1'b1, CLS_ALU}, 1, 0, 0, 0, 0);
        r.exp = dval_only(64'h0000_0000_FFFF_FFFF, 0); rows.push_back(r);
        r.req = instr(8'hFF, 2, 0, 0, 0, 0);
        r.exp = dval_only(64'h0506_0708_0102_0304, 1); rows.push_back(r);
        r.req = instr(OP_TO_BE, 2, 0, 0, 64, 0);
        r.exp = dval_only(64'h0403_0201_0807_0605, 0); rows.push_back(r);
        r.req = instr(OP_TO_LE, 2, 0, 0, 16, 0);
        r.exp = dval_only(64'h0605, 0); rows.push_back(r);
        r.req = instr(OP_TO_BE, 2, 0, 0, 7, 0);
        r.exp = dval_only(64'h0605, 0); rows.push_back(r);
        r.req = instr(OP_LDDW, 15, 0, 0, 5, 5);
        r.exp = dval_only(0, 0); rows.push_back(r);
        r.has_exp = 0;
        r.req = instr(OP_EXIT, 0, 0, 0, 0, 0); rows.push_back(r);
        r.req = instr(OP_JA, 0, 0, 16'h8000, 0, 0); rows.push_back(r);
        r.req = instr({JMP_JSGT, 1'b0, CLS_JMP}, 1, 0, 16'h7FFF, 32'h8000_0000, 0);
        rows.push_back(r);
        r.req = instr({JMP_JGT, 1'b1, CLS_JMP}, 1, 2, 3, 0, 0); rows.push_back(r);
        r.req = instr({ALU_ARSH, 1'b0, CLS_ALU64}, 1, 0, 0, 63, 0); rows.push_back(r);
        r.req = instr({ALU_LSH, 1'b1, CLS_ALU}, 2, 1, 0, 0, 0); rows.push_back(r);
        r.req = instr(OP_NEG, 2, 0, 0, 0, 0); rows.push_back(r);
        r.req = instr(OP_NEG64, 2, 0, 0, 0, 0); rows.push_back(r);
        r.req = instr({ALU_MUL, 1'b0, CLS_ALU64}, 2, 0, 0, 32'h7FFF_FFFF, 0); rows.push_back(r);
        r.req = instr(8'h79, 4, 1, 16'h8000, 0, 0); rows.push_back(r);
        r.req = instr(8'h72, 2, 0, 16'h7FFF, 32'h8000_0000, 0); rows.push_back(r);
        r.req = instr(8'h7B, 9, 1, 16'hFFFF, 0, 0); rows.push_back(r);
        r.req = '0; r.req.kind = 1'b1; r.req.ldata = 64'h8000_0000_0000_0001; rows.push_back(r);
        r.req = instr({ALU_DIV, 1'b1, CLS_ALU}, 4, 2, 0, 0, 0); rows.push_back(r);
        foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
        wait_drained();

        // Random phases with varied idling, plus a long receiver hold-off
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 60; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 60;
                end
                3:
                begin
                    send_idle_pct = 32; recv_stall_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
            endcase
            if (ph == 4)
            begin
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (400) @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            begin
                send_request(random_request(), 0, '0);
                // Pause once until all results are back
                if (ph == 1 && n == 100)
                begin
                    s_tvalid <= 1'b0;
                    while (expected_results.size() != 0) @(posedge clk);
                end
            end
        end
        wait_drained();

        if (errors == 0)
            $display("PASS ebpf_instruction_execute_top");
        else
            $display("FAIL ebpf_instruction_execute_top");
        $finish;
    end

endmodule

`default_nettype wire

// ----- ebpf_instruction_execute_top.f -----
src/ebpf_ie_pkg.sv
src/ebpf_ie_alu.sv
src/ebpf_instruction_execute_top.sv
tb/tb_ebpf_instruction_execute_top.sv
